FILE: rtl/core/sha256mh_pkg.sv
// Package for the SHA-256 message hasher: round constants, initial hash values,
// input kind codes and the sigma functions of the compression round.
// No dependencies.
`default_nettype none

package sha256mh_pkg;

    typedef logic [31:0] word_t;
    typedef logic [1:0]  kind_t;

    localparam kind_t KIND_BYTE = 2'd0;
    localparam kind_t KIND_LAST = 2'd1;
    localparam kind_t KIND_END  = 2'd2;

    localparam word_t INIT_H [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sha256_message_hasher.sv
// SHA-256 message hasher: byte intake, padding sequencer, one-round-per-cycle
// compression unit and digest word output.
// Depends on sha256mh_pkg.
//
//  channel | ports                            | direction | beat
//  --------+----------------------------------+-----------+-------------------------
//  message | msg_valid, msg_stall, kind,      | in        | one byte or end mark
//          | data_byte                        |           |
//  digest  | word_valid, word_stall,          | out       | one digest word, eight
//          | digest_word, word_last           |           | per message
//
//  A byte beat is taken while the sequencer is idle; a beat that completes a 64-byte
//  block holds the message channel through its 64 rounds and one sum.
//  An end of message runs padding one byte per cycle through the same intake,
//  pausing for each compressed block, then offers eight words.
//  rst_n clears the sequencer, byte count and fill, and reloads the initial hash.
//  msg_stall is high whenever the sequencer is not idle; word_stall holds a word.
`default_nettype none

module sha256_message_hasher
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       msg_valid,
    output logic                            msg_stall,
    input  wire sha256mh_pkg::kind_t        kind,
    input  wire logic [7:0]                 data_byte,
    output logic                            word_valid,
    input  wire logic                       word_stall,
    output logic [31:0]                     digest_word,
    output logic                            word_last
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MARK  = 3'd1;
    localparam logic [2:0] S_PAD   = 3'd2;
    localparam logic [2:0] S_LEN   = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  ret_reg, ret_next;
    logic [5:0]  fill_reg;
    logic [5:0]  round_reg;
    logic [2:0]  emit_reg;
    logic [60:0] count_reg, count_next;
    logic [63:0] len_reg, len_next;
    logic [23:0] acc_reg;

    sha256mh_pkg::word_t chain_reg [8];
    sha256mh_pkg::word_t w_reg [16];
    sha256mh_pkg::word_t a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;

    logic        absorb;
    logic [7:0]  absorb_byte;
    logic        start_round;
    logic        emit_take;

    sha256mh_pkg::word_t t1, t2, w_new, ch, maj;

    assign msg_stall   = (state_reg != S_IDLE);
    assign word_valid  = (state_reg == S_EMIT);
    assign digest_word = chain_reg[0];
    assign word_last   = (emit_reg == 3'd7);
    assign emit_take   = word_valid && !word_stall;

    assign ch    = (e_reg & f_reg) ^ (~e_reg & g_reg);
    assign maj   = (a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg);
    assign t1    = h_reg + sha256mh_pkg::big_sigma1(e_reg) + ch
                   + sha256mh_pkg::ROUND_K[round_reg] + w_reg[0];
    assign t2    = sha256mh_pkg::big_sigma0(a_reg) + maj;
    assign w_new = w_reg[0] + sha256mh_pkg::small_sigma0(w_reg[1]) + w_reg[9]
                   + sha256mh_pkg::small_sigma1(w_reg[14]);

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        absorb      = 1'b0;
        absorb_byte = 8'h00;
        start_round = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (msg_valid)
                begin
                    if (kind == sha256mh_pkg::KIND_BYTE || kind == sha256mh_pkg::KIND_LAST)
                    begin
                        absorb      = 1'b1;
                        absorb_byte = data_byte;
                        count_next  = count_reg + 61'd1;
                    end
                    if (kind == sha256mh_pkg::KIND_LAST || kind == sha256mh_pkg::KIND_END)
                    begin
                        len_next = {count_next, 3'b000};
                    end
                    if (absorb && fill_reg == 6'd63)
                    begin
                        start_round = 1'b1;
                        state_next  = S_ROUND;
                        ret_next    = (kind == sha256mh_pkg::KIND_LAST) ? S_MARK : S_IDLE;
                    end
                    else if (kind == sha256mh_pkg::KIND_LAST ||
                             kind == sha256mh_pkg::KIND_END)
                    begin
                        state_next = S_MARK;
                    end
                end
            end
            S_MARK:
            begin
                absorb      = 1'b1;
                absorb_byte = 8'h80;
                if (fill_reg == 6'd63)
                begin
                    start_round = 1'b1;
                    state_next  = S_ROUND;
                    ret_next    = S_PAD;
                end
                else
                begin
                    state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                if (fill_reg == 6'd56)
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    absorb = 1'b1;
                    if (fill_reg == 6'd63)
                    begin
                        start_round = 1'b1;
                        state_next  = S_ROUND;
                        ret_next    = S_PAD;
                    end
                end
            end
            S_LEN:
            begin
                absorb      = 1'b1;
                absorb_byte = len_reg[63:56];
                len_next    = {len_reg[55:0], 8'h00};
                if (fill_reg == 6'd63)
                begin
                    start_round = 1'b1;
                    state_next  = S_ROUND;
                    ret_next    = S_EMIT;
                end
            end
            S_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = ret_reg;
            end
            S_EMIT:
            begin
                if (emit_take && emit_reg == 3'd7)
                begin
                    state_next = S_IDLE;
                    count_next = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            fill_reg  <= '0;
            round_reg <= '0;
            emit_reg  <= '0;
            count_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sha256mh_pkg::INIT_H[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            count_reg <= count_next;
            if (absorb)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (start_round)
            begin
                round_reg <= '0;
            end
            else if (state_reg == S_ROUND)
            begin
                round_reg <= round_reg + 6'd1;
            end
            if (state_reg == S_SUM)
            begin
                emit_reg     <= '0;
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
                chain_reg[5] <= chain_reg[5] + f_reg;
                chain_reg[6] <= chain_reg[6] + g_reg;
                chain_reg[7] <= chain_reg[7] + h_reg;
            end
            else if (emit_take)
            begin
                emit_reg <= emit_reg + 3'd1;
                if (emit_reg == 3'd7)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_reg[i] <= sha256mh_pkg::INIT_H[i];
                    end
                end
                else
                begin
                    for (int i = 0; i < 7; i++)
                    begin
                        chain_reg[i] <= chain_reg[i + 1];
                    end
                    chain_reg[7] <= chain_reg[0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        if (absorb)
        begin
            acc_reg <= {acc_reg[15:0], absorb_byte};
            if (fill_reg[1:0] == 2'd3)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[15] <= {acc_reg, absorb_byte};
            end
        end
        else if (state_reg == S_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
        end
        if (start_round)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
            f_reg <= chain_reg[5];
            g_reg <= chain_reg[6];
            h_reg <= chain_reg[7];
        end
        else if (state_reg == S_ROUND)
        begin
            h_reg <= g_reg;
            g_reg <= f_reg;
            f_reg <= e_reg;
            e_reg <= d_reg + t1;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= a_reg;
            a_reg <= t1 + t2;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && round_reg == 6'd63) |=> (state_reg == S_SUM))
        else $error("compression did not end after the last round");

    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |-> (fill_reg == 6'd0))
        else $error("digest offered with a partly filled block");

    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_take && word_last) |=> (state_reg == S_IDLE && count_reg == 61'd0
                                      && chain_reg[0] == sha256mh_pkg::INIT_H[0]))
        else $error("state not restored after the final digest word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEN) |-> (fill_reg >= 6'd56))
        else $error("length bytes placed below the length field");

endmodule

`default_nettype wire
